// ===== rtl/core/audio_peak_compressor_macros.svh =====
// Assertion macros shared by the audio peak compressor RTL.
`ifndef AUDIO_PEAK_COMPRESSOR_MACROS_SVH
`define AUDIO_PEAK_COMPRESSOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/apc_pkg.sv =====
// Package with constants, types, tables and functions of the audio peak compressor.
`default_nettype none

package apc_pkg;

    // Buffer and table sizes.
    localparam int BUF_N  = 64;
    localparam int LOG_N  = 256;
    localparam int ADDR_W = $clog2(BUF_N);
    localparam int FILL_W = $clog2(BUF_N + 1);
    localparam int LOG_W  = $clog2(LOG_N);
    localparam int LOG_NW = $clog2(LOG_N + 1);

    // Configuration port.
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [23:0] ONE_Q22 = 24'h400000;
    localparam logic [23:0] MAX24   = 24'hFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_SLOPE     = 3'd1,
        REG_ATTACK    = 3'd2,
        REG_RELEASE   = 3'd3,
        REG_GAIN      = 3'd4,
        REG_STEREO    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FADE_IDLE    = 2'd0,
        FADE_ATTACK  = 2'd1,
        FADE_RELEASE = 2'd2
    } fade_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic tgt_log;
        logic tgt_mul;
        logic tgt_set;
        logic rd;
        logic mul1;
        logic emit;
    } apc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic buf_end;
        logic last_idx;
        logic out_free;
    } apc_stat_t;

    typedef logic [15:0] log_tab_t [LOG_N];
    typedef logic [23:0] exp_tab_t [LOG_N];

    // Truncated integer square root, used only while building the tables.
    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = val;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // log2(1 + i/N) in Q16 by repeated squaring.
    function automatic log_tab_t build_log_tab();
        log_tab_t    t;
        logic [63:0] v;
        logic [15:0] acc;
        for (int i = 0; i < LOG_N; i++) begin
            v   = (64'(LOG_N + i) << 30) / LOG_N;
            acc = 16'd0;
            for (int k = 1; k <= 16; k++) begin
                v = (v * v) >> 30;
                if (v >= (64'd1 << 31)) begin
                    v = v >> 1;
                    acc[16-k] = 1'b1;
                end
            end
            t[i] = acc;
        end
        return t;
    endfunction

    // 2^(i/N) in Q22 as a product of binary roots of two.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] roots [17];
        logic [63:0] f;
        logic [63:0] e;
        roots[0] = 64'd2 << 30;
        for (int k = 1; k <= 16; k++) begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        for (int i = 0; i < LOG_N; i++) begin
            f = (64'(i) << 16) / LOG_N;
            e = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                if (f[16-k]) begin
                    e = (e * roots[k]) >> 30;
                end
            end
            t[i] = e[31:8];
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();
    localparam exp_tab_t EXP_TAB = build_exp_tab();

    // log2 of a nonzero 16-bit value in Q16.
    function automatic logic [19:0] log2_q16(input logic [15:0] x);
        logic [3:0]          e;
        logic [15:0]         m;
        logic [15+LOG_NW-1:0] sc;
        logic [LOG_NW-1:0]   idx;
        e = 4'd0;
        for (int j = 0; j < 16; j++) begin
            if (x[j]) begin
                e = 4'(j);
            end
        end
        m   = x << (4'd15 - e);
        sc  = (15+LOG_NW)'(m[14:0]) * (15+LOG_NW)'(LOG_N);
        idx = sc[15+LOG_NW-1:15];
        if (idx >= LOG_NW'(LOG_N)) begin
            idx = LOG_NW'(LOG_N - 1);
        end
        return {e, 16'd0} + 20'(LOG_TAB[idx[LOG_W-1:0]]);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/apc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module apc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/apc_ctrl.sv =====
// Controller state machine of the audio peak compressor.
`default_nettype none

module apc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire apc_pkg::apc_stat_t stat,
    output apc_pkg::apc_cmd_t       cmd
);
    import apc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOG  = 7'b0000010,
        ST_TMUL = 7'b0000100,
        ST_SET  = 7'b0001000,
        ST_READ = 7'b0010000,
        ST_MUL1 = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && stat.buf_end) begin
                    state_next = ST_LOG;
                end
            end
            ST_LOG:  state_next = ST_TMUL;
            ST_TMUL: state_next = ST_SET;
            ST_SET:  state_next = ST_READ;
            ST_READ: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_EMIT;
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = stat.last_idx ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Command decode.
    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.store   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.tgt_log = (state_reg == ST_LOG);
    assign cmd.tgt_mul = (state_reg == ST_TMUL);
    assign cmd.tgt_set = (state_reg == ST_SET);
    assign cmd.rd      = (state_reg == ST_READ);
    assign cmd.mul1    = (state_reg == ST_MUL1);
    assign cmd.emit    = (state_reg == ST_EMIT) && stat.out_free;

endmodule

`default_nettype wire

// ===== rtl/core/apc_datapath.sv =====
// Datapath of the audio peak compressor: store, peaks, gain target, level and scaling.
`default_nettype none

module apc_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [apc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [apc_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic [15:0]                       s_tdata,
    input  wire logic                              s_tlast,
    output logic      [15:0]                       m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire apc_pkg::apc_cmd_t                 cmd,
    output apc_pkg::apc_stat_t                     stat
);
    import apc_pkg::*;

    // Configuration registers.
    logic [14:0] thr_reg;
    logic [15:0] slope_reg;
    logic [22:0] att_reg;
    logic [23:0] rel_reg;
    logic [15:0] gain_reg;
    logic        stereo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= 15'd8192;
            slope_reg  <= 16'd16384;
            att_reg    <= 23'd4194000;
            rel_reg    <= 24'd4194600;
            gain_reg   <= 16'd4096;
            stereo_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: thr_reg    <= cfg_wdata[14:0];
                REG_SLOPE:     slope_reg  <= cfg_wdata[15:0];
                REG_ATTACK:    att_reg    <= cfg_wdata[22:0];
                REG_RELEASE:   rel_reg    <= cfg_wdata[23:0];
                REG_GAIN:      gain_reg   <= cfg_wdata[15:0];
                REG_STEREO:    stereo_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // State.
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] n_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [14:0]       pl_reg;
    logic [14:0]       pr_reg;
    logic [23:0]       level_reg;
    logic [23:0]       target_reg;
    fade_t             mode_reg;
    logic              over_reg;
    logic [20:0]       d_reg;
    logic [21:0]       p_reg;
    logic [39:0]       p1_reg;
    logic              neg_reg;
    logic              m_valid_reg;
    logic [15:0]       m_data_reg;
    logic              m_last_reg;
    logic [15:0]       ram_q;

    // Incoming word magnitude, most negative value counted as full scale.
    logic [15:0] s_abs;
    logic [14:0] s_mag;
    logic        right_lane;

    assign s_abs      = s_tdata[15] ? (16'd0 - s_tdata) : s_tdata;
    assign s_mag      = s_abs[15] ? 15'h7FFF : s_abs[14:0];
    assign right_lane = stereo_reg && fill_reg[0];

    // Sample store.
    apc_ram #(
        .WIDTH(16),
        .DEPTH(BUF_N)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (cmd.store),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (cmd.rd),
        .rd_addr (k_reg),
        .rd_data (ram_q)
    );

    // Status to the controller.
    assign stat.buf_end  = s_tlast || (fill_reg == FILL_W'(BUF_N - 1));
    assign stat.last_idx = (FILL_W'(k_reg) + FILL_W'(1)) == n_reg;
    assign stat.out_free = !m_valid_reg || m_tready;

    // Log difference of peak sum and doubled threshold.
    logic [15:0] sum;
    logic [15:0] t2;
    logic [19:0] la;
    logic [19:0] lb;
    logic [20:0] d_next;

    assign sum = {1'b0, pl_reg} + {1'b0, pr_reg};
    assign t2  = {thr_reg, 1'b0};
    assign la  = log2_q16(t2);
    assign lb  = log2_q16(sum);

    always_comb begin
        if (t2 == 16'd0) begin
            d_next = 21'd1572864;
        end else if (lb > la) begin
            d_next = 21'(lb - la);
        end else begin
            d_next = 21'd0;
        end
    end

    // Slope product.
    logic [36:0] dprod;

    assign dprod = 37'(d_reg) * 37'(slope_reg);

    // Gain target from the exponent table.
    logic [5:0]            q;
    logic [15:0]           r;
    logic [16:0]           rdiff;
    logic [17+LOG_NW-1:0]  tsc;
    logic [LOG_NW-1:0]     tidx;
    logic [6:0]            qp1;
    logic [23:0]           tgt;

    assign q     = p_reg[21:16];
    assign r     = p_reg[15:0];
    assign rdiff = 17'h10000 - {1'b0, r};
    assign tsc   = (17+LOG_NW)'(rdiff) * (17+LOG_NW)'(LOG_N);
    assign qp1   = {1'b0, q} + 7'd1;

    always_comb begin
        tidx = tsc[16+LOG_NW-1:16];
        if (tidx >= LOG_NW'(LOG_N)) begin
            tidx = LOG_NW'(LOG_N - 1);
        end
        if (r == 16'd0) begin
            tgt = (q > 6'd22) ? 24'd0 : (ONE_Q22 >> q);
        end else if (qp1 >= 7'd23) begin
            tgt = 24'd0;
        end else begin
            tgt = EXP_TAB[tidx[LOG_W-1:0]] >> qp1;
        end
    end

    // Output scaling and saturation.
    logic [15:0] rd_mag;
    logic [55:0] p2;
    logic [21:0] prod;
    logic [15:0] pos_out;
    logic [15:0] neg_mag;
    logic [15:0] out_word;

    assign rd_mag  = ram_q[15] ? (16'd0 - ram_q) : ram_q;
    assign p2      = 56'(p1_reg) * 56'(gain_reg);
    assign prod    = p2[55:34];
    assign pos_out = (prod > 22'd32767) ? 16'h7FFF : prod[15:0];
    assign neg_mag = (prod > 22'd32768) ? 16'h8000 : prod[15:0];
    assign out_word = neg_reg ? (16'd0 - neg_mag) : pos_out;

    // Level step toward the target.
    logic [23:0] factor;
    logic [47:0] nl;
    logic [25:0] nl_shr;
    logic        reached;
    logic        do_fade;

    assign factor  = (mode_reg == FADE_ATTACK) ? {1'b0, att_reg} : rel_reg;
    assign nl      = 48'(level_reg) * 48'(factor);
    assign nl_shr  = nl[47:22];
    assign reached = ((factor > ONE_Q22) && (level_reg >= target_reg)) ||
                     ((factor < ONE_Q22) && (level_reg <= target_reg));
    assign do_fade = cmd.emit && (!stereo_reg || !k_reg[0]);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            pl_reg      <= '0;
            pr_reg      <= '0;
            level_reg   <= ONE_Q22;
            target_reg  <= ONE_Q22;
            mode_reg    <= FADE_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.store) begin
                fill_reg <= fill_reg + FILL_W'(1);
                if (right_lane) begin
                    if (s_mag > pr_reg) begin
                        pr_reg <= s_mag;
                    end
                end else begin
                    if (s_mag > pl_reg) begin
                        pl_reg <= s_mag;
                    end
                end
            end
            if (cmd.tgt_log) begin
                fill_reg <= '0;
                pl_reg   <= '0;
                pr_reg   <= '0;
            end
            if (cmd.tgt_set) begin
                if (over_reg) begin
                    target_reg <= tgt;
                    mode_reg   <= FADE_ATTACK;
                end else begin
                    target_reg <= ONE_Q22;
                    mode_reg   <= FADE_RELEASE;
                end
            end
            if (do_fade) begin
                case (mode_reg)
                    FADE_ATTACK, FADE_RELEASE: begin
                        if (reached) begin
                            mode_reg <= FADE_IDLE;
                        end else begin
                            level_reg <= (nl_shr > 26'(MAX24)) ? MAX24 : nl_shr[23:0];
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.tgt_log) begin
            over_reg <= sum > t2;
            d_reg    <= d_next;
            n_reg    <= fill_reg;
            k_reg    <= '0;
        end
        if (cmd.tgt_mul) begin
            p_reg <= dprod[36:15];
        end
        if (cmd.mul1) begin
            p1_reg  <= 40'(rd_mag) * 40'(level_reg);
            neg_reg <= ram_q[15];
        end
        if (cmd.emit) begin
            m_data_reg <= out_word;
            m_last_reg <= stat.last_idx;
            k_reg      <= k_reg + ADDR_W'(1);
        end
    end

    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/audio_peak_compressor.sv =====
// Top level of the audio peak compressor.
// While idle, the block takes one input word per cycle into a 64-entry sample RAM,
// tracking the channel peaks; a word that is not the last of its buffer produces no
// output. When the buffer ends (tlast, or the 64th word) the gain target is formed by a
// log lookup, a slope multiply and an exponent lookup, and then every stored word is sent
// out by a read of the sample RAM's registered port, the level multiply and the gain
// multiply; the gain multiply waits while m_tready is low and the output register is full.
// Input is taken again once the final output word sits in the output register. No
// clearing pass follows reset.
`default_nettype none
`include "audio_peak_compressor_macros.svh"

module audio_peak_compressor (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port.
    input  wire logic                          cfg_wr_en,
    input  wire logic [apc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [apc_pkg::CFG_W-1:0]     cfg_wdata,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // [15:0] sample_in
    input  wire logic                          s_tlast,   // last_of_buffer
    // Output stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [15:0]                   m_tdata,   // [15:0] sample_out
    output logic                               m_tlast    // last_out
);
    import apc_pkg::*;

    apc_cmd_t  cmd;
    apc_stat_t stat;

    apc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    apc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // A scaled word is presented in the cycle after it is computed.
    `APC_ASSERT_NEXT(a_emit_presents, cmd.emit, m_tvalid, "scaled word not presented")
    // The target pipeline never skips its multiply step.
    `APC_ASSERT_NEXT(a_log_then_mul, cmd.tgt_log, cmd.tgt_mul, "target multiply skipped")
    // Input is taken only while no output word is being produced.
    `APC_ASSERT_SAME(a_ready_quiet, s_tready, !(cmd.rd || cmd.mul1 || cmd.emit),
        "input ready during emission")

endmodule

`default_nettype wire

// ===== dv/tb_audio_peak_compressor.sv =====
// Self-checking testbench for the audio peak compressor: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_audio_peak_compressor;
    import apc_pkg::*;

    localparam int          DEPTH    = 64;
    localparam int          TAB_N    = 256;
    localparam int unsigned UNITY    = 32'd4194304;
    localparam int unsigned LEVEL_MX = 32'd16777215;

    typedef struct packed {
        logic [15:0] smp;
        logic        lst;
    } out_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 m_tlast;

    audio_peak_compressor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [15:0] sample_in
        .s_tlast   (s_tlast),   // last_of_buffer
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [15:0] sample_out
        .m_tlast   (m_tlast)    // last_out
    );

    // Shadow configuration and compressor state.
    int unsigned thresh_q, slope_q, attack_q, release_q, makeup_q, stereo_q;
    logic [15:0] held_words [DEPTH];
    int unsigned held_count, peak_l, peak_r, level_q, target_q;
    fade_t       fade_q;
    int unsigned log_frac [TAB_N];
    int unsigned pow_frac [TAB_N];

    out_word_t   expected_words [$];
    int          mismatches = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b0;
    int          stall_mode = 0;
    int          stall_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned val);
        longint unsigned v, res, b;
        v   = val;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Fractional log2 and exp2 tables built with truncating fixed-point steps.
    task automatic build_curves();
        longint unsigned roots [17];
        longint unsigned v, f, e;
        int unsigned     acc;
        roots[0] = 64'd2 << 30;
        for (int k = 1; k <= 16; k++) roots[k] = int_sqrt(roots[k-1] << 30);
        for (int i = 0; i < TAB_N; i++) begin
            v   = (longint'(TAB_N + i) << 30) / TAB_N;
            f   = (longint'(i) << 16) / TAB_N;
            e   = 64'd1 << 30;
            acc = 0;
            for (int k = 1; k <= 16; k++) begin
                v = (v * v) >> 30;
                if (v >= (64'd1 << 31)) begin
                    v   = v >> 1;
                    acc = acc | (1 << (16 - k));
                end
                if ((f >> (16 - k)) & 1) e = (e * roots[k]) >> 30;
            end
            log_frac[i] = acc;
            pow_frac[i] = int'(e >> 8);
        end
    endtask

    function automatic int unsigned log2_fix(input int unsigned x);
        int unsigned     ex, m;
        longint unsigned idx;
        ex = 15;
        while (ex > 0 && ((x >> ex) & 1) == 0) ex--;
        m   = (x << (15 - ex)) & 16'hFFFF;
        idx = ((longint'(m) - 32768) * TAB_N) >> 15;
        if (idx >= TAB_N) idx = TAB_N - 1;
        return (ex << 16) + log_frac[idx];
    endfunction

    // Gain target for a peak sum above twice the threshold.
    function automatic int unsigned gain_for_peaks(input int unsigned sum, input int unsigned t2);
        longint unsigned d, p, q, r, idx;
        int unsigned     a, b;
        if (t2 == 0) begin
            d = 64'd24 << 16;
        end else begin
            a = log2_fix(t2);
            b = log2_fix(sum);
            d = (b > a) ? longint'(b - a) : 0;
        end
        p = (d * slope_q) >> 15;
        q = p >> 16;
        r = p & 16'hFFFF;
        if (r == 0) return (q > 22) ? 0 : (UNITY >> q);
        if (q + 1 >= 23) return 0;
        idx = ((65536 - r) * TAB_N) >> 16;
        if (idx >= TAB_N) idx = TAB_N - 1;
        return pow_frac[idx] >> (q + 1);
    endfunction

    // One geometric level step toward the target.
    function automatic void step_level();
        int unsigned     factor;
        longint unsigned nl;
        if (fade_q != FADE_ATTACK && fade_q != FADE_RELEASE) return;
        factor = (fade_q == FADE_ATTACK) ? attack_q : release_q;
        if ((factor > UNITY && level_q >= target_q) ||
            (factor < UNITY && level_q <= target_q)) begin
            fade_q = FADE_IDLE;
            return;
        end
        nl      = (longint'(level_q) * factor) >> 22;
        level_q = (nl > LEVEL_MX) ? LEVEL_MX : int'(nl);
    endfunction

    function automatic logic [15:0] scale_word(input logic [15:0] smp);
        longint unsigned mag, prod;
        mag  = smp[15] ? longint'(65536 - smp) : longint'(smp);
        prod = (mag * level_q * makeup_q) >> 34;
        if (smp[15]) begin
            if (prod > 32768) prod = 32768;
            return 16'((65536 - prod) & 16'hFFFF);
        end
        return (prod > 32767) ? 16'h7FFF : 16'(prod);
    endfunction

    // Store one accepted word; at the end of a buffer queue every scaled word.
    function automatic void absorb_word(input logic [15:0] smp, input logic lst);
        int unsigned mag, sum;
        out_word_t   w;
        mag = smp[15] ? 65536 - smp : smp;
        if (mag > 32767) mag = 32767;
        if (held_count >= DEPTH) held_count = 0;
        if (stereo_q != 0 && held_count[0]) begin
            if (mag > peak_r) peak_r = mag;
        end else begin
            if (mag > peak_l) peak_l = mag;
        end
        held_words[held_count] = smp;
        held_count++;
        if (!lst && held_count < DEPTH) return;
        sum = peak_l + peak_r;
        if (sum > 2 * thresh_q) begin
            target_q = gain_for_peaks(sum, 2 * thresh_q);
            fade_q   = FADE_ATTACK;
        end else begin
            target_q = UNITY;
            fade_q   = FADE_RELEASE;
        end
        for (int k = 0; k < held_count; k++) begin
            w.smp = scale_word(held_words[k]);
            w.lst = (k + 1 == held_count);
            expected_words.push_back(w);
            if (stereo_q == 0 || k % 2 == 0) step_level();
        end
        held_count = 0;
        peak_l     = 0;
        peak_r     = 0;
    endfunction

    // Send one word, keeping bursts of back-to-back words between random gaps.
    task automatic send_word(input logic [15:0] smp, input logic lst);
        if (burst_left <= 0) begin
            if (gaps_on) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tdata  = smp;
        s_tlast  = lst;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        absorb_word(smp, lst);
        @(negedge aclk);
        s_tvalid = 1'b0;
        burst_left--;
    endtask

    task automatic send_buffer(input int len);
        for (int i = 0; i < len; i++) send_word(16'($urandom), i == len - 1);
    endtask

    // Let every expected word drain, then give the pipeline time to settle.
    task automatic wait_idle();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = CFG_W'(val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_THRESHOLD: thresh_q  = val & 32'h7FFF;
            REG_SLOPE:     slope_q   = val & 32'hFFFF;
            REG_ATTACK:    attack_q  = val & 32'h7FFFFF;
            REG_RELEASE:   release_q = val & 32'hFFFFFF;
            REG_GAIN:      makeup_q  = val & 32'hFFFF;
            REG_STEREO:    stereo_q  = val & 1;
            default: ;
        endcase
    endtask

    // Receiver: ready with occasional stalls of random length, or always ready.
    always @(negedge aclk) begin
        if (stall_mode == 0) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, (stall_mode == 1) ? 2 : 20);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each output word with the oldest expected one.
    always @(posedge aclk) begin
        out_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: data %h last %b", m_tdata, m_tlast);
            end else begin
                w = expected_words.pop_front();
                if (m_tdata !== w.smp || m_tlast !== w.lst) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected data %h last %b, got data %h last %b",
                                 w.smp, w.lst, m_tdata, m_tlast);
                end
            end
        end
    end

    // Reset configuration, field extremes and mixed signs.
    task automatic test_defaults();
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b1);
        wait_idle();
    endtask

    // A full buffer ends at its last entry without a last marker.
    task automatic test_full_buffer();
        for (int i = 0; i < DEPTH; i++) send_word(16'($urandom), 1'b0);
        send_word(16'h0001, 1'b1);
        wait_idle();
    endtask

    // A mono buffer, an odd stereo buffer, and a mode change inside a buffer.
    task automatic test_channel_modes();
        write_reg(REG_STEREO, 0);
        send_word(16'h6000, 1'b0);
        send_word(16'h9000, 1'b1);
        wait_idle();
        write_reg(REG_STEREO, 1);
        send_word(16'h7000, 1'b0);
        send_word(16'h0100, 1'b0);
        send_word(16'h8000, 1'b1);
        wait_idle();
        send_word(16'h4000, 1'b0);
        wait_idle();
        write_reg(REG_STEREO, 0);
        send_word(16'hC000, 1'b0);
        wait_idle();
        write_reg(REG_STEREO, 1);
        send_word(16'h7FFF, 1'b1);
        wait_idle();
    endtask

    // Register extremes: zero and full threshold, slope, unity factors, gain.
    task automatic test_register_extremes();
        write_reg(REG_THRESHOLD, 0);
        send_buffer(2);
        wait_idle();
        write_reg(REG_THRESHOLD, 32767);
        write_reg(REG_RELEASE, 16777215);
        send_buffer(2);
        wait_idle();
        write_reg(REG_THRESHOLD, 1000);
        write_reg(REG_SLOPE, 0);
        send_word(16'h7FFF, 1'b1);
        wait_idle();
        write_reg(REG_SLOPE, 32768);
        write_reg(REG_ATTACK, 4194304);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b1);
        wait_idle();
        write_reg(REG_ATTACK, 3000000);
        write_reg(REG_RELEASE, 4194304);
        write_reg(REG_GAIN, 65535);
        send_word(16'h1234, 1'b1);
        wait_idle();
        write_reg(REG_GAIN, 0);
        send_word(16'h7FFF, 1'b1);
        wait_idle();
        write_reg(REG_GAIN, 4096);
        write_reg(REG_RELEASE, 4400000);
    endtask

    // Random buffers with random settings, gaps and stalls.
    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 16) begin
            gaps_on    = $urandom_range(0, 1);
            stall_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                write_reg(REG_THRESHOLD, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 32767) : $urandom_range(0, 12000));
                write_reg(REG_SLOPE, $urandom_range(0, 32768));
                write_reg(REG_ATTACK, $urandom_range(3800000, 4194304));
                write_reg(REG_RELEASE, $urandom_range(4194304, 5000000));
                write_reg(REG_GAIN, ($urandom_range(0, 5) == 0) ?
                          65535 : $urandom_range(2048, 8192));
                write_reg(REG_STEREO, $urandom_range(0, 1));
            end
            len = $urandom_range(1, 8);
            send_buffer(len);
            sent += len;
        end
        wait_idle();
    endtask

    // Zero attack factor drives the level to zero, where it stays.
    task automatic test_level_floor();
        write_reg(REG_THRESHOLD, 100);
        write_reg(REG_ATTACK, 0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h4000, 1'b1);
        wait_idle();
        send_buffer(3);
    endtask

    initial begin
        build_curves();
        thresh_q   = 8192;
        slope_q    = 16384;
        attack_q   = 4194000;
        release_q  = 4194600;
        makeup_q   = 4096;
        stereo_q   = 1;
        held_count = 0;
        peak_l     = 0;
        peak_r     = 0;
        level_q    = UNITY;
        target_q   = UNITY;
        fade_q     = FADE_IDLE;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_defaults();
        stall_mode = 2;
        gaps_on    = 1'b1;
        test_full_buffer();
        stall_mode = 1;
        test_channel_modes();
        test_register_extremes();
        test_random();
        test_level_floor();

        while (expected_words.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
